@@ hw/rtl/hcsp_pkg.sv @@
`timescale 1ns / 1ps

package hcsp_pkg;

	localparam int MAX_PILLARS_DEF = 16;

	localparam int CFG_W   = 5;
	localparam int TIME_W  = 32;
	localparam int RATE_W  = 32;
	localparam int IDX_W   = 4;
	localparam int SURV_W  = 32;
	localparam int S_DATA_W = 136;

	// Fixed-point anchors of the exponential datapath (Q.60).
	localparam logic [63:0] ONE60     = 64'h1000_0000_0000_0000;
	localparam logic [63:0] FLOOR58   = 64'h0400_0000_0000_0000;
	localparam logic [63:0] RDIV_INIT = 64'h0200_0000_0000_0000;
	localparam logic [63:0] HALF_Q230 = 64'h0000_0000_2000_0000;

	// Number of Taylor terms of exp(-f).
	localparam logic [4:0] LAST_TERM = 5'd24;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_SURV  = 2'd1,
		OP_RATIO = 2'd2
	} op_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_CH_START,
		S_CH_RD,
		S_CH_EVAL,
		S_CH_ACC,
		S_CH_DONE,
		S_EXP,
		S_MUL,
		S_EF_DIV,
		S_EF_UPD,
		S_EF_END,
		S_POW,
		S_FIN,
		S_RDIV,
		S_RRND,
		S_OUT
	} state_t;

endpackage

@@ hw/rtl/hcsp_ram.sv @@
`timescale 1ns / 1ps

module hcsp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/hazard_curve_survival_probability_unit.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Signals                  Contents (lowest bit first)
// s_*       in         tvalid tready tdata tuser tdata: pillar_index[3:0], pillar_end_time,
//                                               pillar_rate, query_time, horizon_time, pad
//                                               tuser: opcode
// m_*       out        tvalid tready tdata tuser tdata: survival; tuser: saturated
// cfg_*     in         we wdata                 pillars_in_use
//
// A pillar write or an unused opcode is answered straight from the idle state. A survival
// query walks the curve, reading, evaluating and accumulating each pillar, then runs the
// exp(-f) series (24 terms, each a multiply on the shared 32x32 multiplier and a restoring
// divide by the term index) and one multiply per whole unit of hazard.
// A ratio query walks twice and may add a restoring divide.
// After reset the unit computes exp(-1) before it takes a transfer.
// The input is taken only when the unit is idle and its output register is free or
// being emptied; a stalled result holds in the output register.

module hazard_curve_survival_probability_unit #(
	parameter int MAX_PILLARS = hcsp_pkg::MAX_PILLARS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hcsp_pkg::S_DATA_W-1:0] s_tdata,  // index, end, rate, query, horizon
	input  logic [1:0]                    s_tuser,  // opcode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hcsp_pkg::SURV_W-1:0]   m_tdata,  // survival
	output logic                          m_tuser,  // saturated
	input  logic                          cfg_we,
	input  logic [hcsp_pkg::CFG_W-1:0]    cfg_wdata // pillars_in_use
);

	import hcsp_pkg::*;

	localparam int AW = (MAX_PILLARS > 1) ? $clog2(MAX_PILLARS) : 1;
	localparam int CW = $clog2(MAX_PILLARS + 1);

	// Input fields unpacked from the stream word.
	logic [IDX_W-1:0]  in_idx;
	logic [TIME_W-1:0] in_end;
	logic [RATE_W-1:0] in_rate;
	logic [TIME_W-1:0] in_query;
	logic [TIME_W-1:0] in_horizon;

	assign in_idx     = s_tdata[3:0];
	assign in_end     = s_tdata[35:4];
	assign in_rate    = s_tdata[67:36];
	assign in_query   = s_tdata[99:68];
	assign in_horizon = s_tdata[131:100];

	state_t state_q, state_nx;

	// Control registers.
	logic [CFG_W-1:0] cfg_q;
	logic             ovalid_q;
	logic [5:0]       cnt_q;
	logic [4:0]       k_q;
	logic [5:0]       pow_q;
	logic [CW-1:0]    i_q;
	logic             ph_q;
	logic             ctx_pow_q;
	logic             boot_q;
	logic             fnd_q;

	// Payload registers.
	logic [1:0]   op_q;
	logic [31:0]  t_q;
	logic [31:0]  h_q;
	logic [63:0]  cum_q;
	logic [31:0]  tprev_q;
	logic [63:0]  hs_q;
	logic [63:0]  x_q;
	logic         inv_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q;
	logic [63:0]  mul_a_q;
	logic [63:0]  mul_b_q;
	logic [63:0]  dq_q;
	logic [4:0]   drem_q;
	logic [63:0]  pos_q;
	logic [63:0]  neg_q;
	logic [63:0]  r_q;
	logic [63:0]  em1_q;
	logic [33:0]  q_q;
	logic [63:0]  rrem_q;
	logic [31:0]  fin_q;
	logic         fsat_q;
	logic [31:0]  osurv_q;
	logic         osat_q;

	logic in_fire;
	logic out_free;
	logic [CW-1:0] n_eff;

	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !ovalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign m_tvalid = ovalid_q;
	assign m_tdata  = osurv_q;
	assign m_tuser  = osat_q;

	// Pillars past the configured limit are never read.
	assign n_eff = (32'(cfg_q) > 32'(MAX_PILLARS)) ? CW'(MAX_PILLARS) : CW'(cfg_q);

	// Pillar store: rate in the upper half, end time in the lower half.
	logic          ram_we;
	logic [63:0]   ram_rd;
	logic [31:0]   pil_end;
	logic [31:0]   pil_rate;

	assign ram_we = in_fire && (op_t'(s_tuser) == OP_WRITE)
		&& (32'(in_idx) < 32'(MAX_PILLARS));
	assign pil_end  = ram_rd[31:0];
	assign pil_rate = ram_rd[63:32];

	hcsp_ram #(
		.WIDTH(64),
		.DEPTH(MAX_PILLARS)
	) u_pillars (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(in_idx)),
		.wdata({in_rate, in_end}),
		.raddr(i_q[AW-1:0]),
		.rdata(ram_rd)
	);

	// Segment length of the pillar being walked.
	logic        seg_hit;
	logic [31:0] seg_dt;

	always_comb begin
		seg_hit = pil_end >= t_q;
		if (seg_hit) begin
			seg_dt = (t_q > tprev_q) ? t_q - tprev_q : 32'd0;
		end else begin
			seg_dt = (pil_end > tprev_q) ? pil_end - tprev_q : 32'd0;
		end
	end

	// The one shared 32x32 multiplier: segment products, and the four partial
	// products of each 64x64 multiply, one per cycle.
	logic [1:0]  pj_cur;
	logic [1:0]  pj_prev;
	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [127:0] pp_shift;
	logic [127:0] acc_nx;
	logic [63:0]  mres;

	assign pj_cur  = cnt_q[1:0];
	assign pj_prev = 2'(cnt_q - 6'd1);

	always_comb begin
		if (state_q == S_CH_EVAL) begin
			mul_x = pil_rate;
			mul_y = seg_dt;
		end else begin
			mul_x = pj_cur[0] ? mul_a_q[63:32] : mul_a_q[31:0];
			mul_y = pj_cur[1] ? mul_b_q[63:32] : mul_b_q[31:0];
		end
		case ({1'b0, pj_prev[0]} + {1'b0, pj_prev[1]})
			2'd0:    pp_shift = {64'd0, pp_q};
			2'd1:    pp_shift = {32'd0, pp_q, 32'd0};
			default: pp_shift = {pp_q, 64'd0};
		endcase
		acc_nx = (cnt_q == 6'd0) ? 128'd0 : acc_q + pp_shift;
	end

	assign mres = acc_nx[123:60];

	// Eight restoring steps of the divide by the term index.
	logic [5:0] dv_rw;
	logic [7:0] dv_qb;

	always_comb begin
		dv_rw = {1'b0, drem_q};
		dv_qb = 8'd0;
		for (int b = 0; b < 8; b++) begin
			dv_rw = {dv_rw[4:0], dq_q[63-b]};
			if (dv_rw >= {1'b0, k_q}) begin
				dv_rw = dv_rw - {1'b0, k_q};
				dv_qb[7-b] = 1'b1;
			end
		end
	end

	// Cumulative hazard add, saturating.
	logic [64:0] cum_sum;
	assign cum_sum = {1'b0, cum_q} + {1'b0, pp_q};

	// Ratio divider step.
	logic [63:0] rd_shift;
	logic        rd_ge;
	assign rd_shift = {rrem_q[62:0], 1'b0};
	assign rd_ge    = rd_shift >= r_q;

	logic [34:0] q_rnd;
	assign q_rnd = ({1'b0, q_q} + 35'd1) >> 1;

	logic ch_skip;
	logic ch_last;
	assign ch_skip = (t_q == 32'd0) || t_q[31] || (n_eff == CW'(0));
	assign ch_last = fnd_q || (CW'(i_q + 1'b1) == n_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_INIT:     state_nx = S_MUL;
			S_IDLE: begin
				if (in_fire && (op_t'(s_tuser) == OP_SURV || op_t'(s_tuser) == OP_RATIO)) begin
					state_nx = S_CH_START;
				end
			end
			S_CH_START: state_nx = ch_skip ? S_CH_DONE : S_CH_RD;
			S_CH_RD:    state_nx = S_CH_EVAL;
			S_CH_EVAL:  state_nx = S_CH_ACC;
			S_CH_ACC:   state_nx = ch_last ? S_CH_DONE : S_CH_RD;
			S_CH_DONE: begin
				if (op_t'(op_q) == OP_RATIO && !ph_q) begin
					state_nx = S_CH_START;
				end else begin
					state_nx = S_EXP;
				end
			end
			S_EXP:      state_nx = (x_q[63:58] != 6'd0) ? S_FIN : S_MUL;
			S_MUL: begin
				if (cnt_q == 6'd4) begin
					state_nx = ctx_pow_q ? S_POW : S_EF_DIV;
				end
			end
			S_EF_DIV:   state_nx = (cnt_q == 6'd7) ? S_EF_UPD : S_EF_DIV;
			S_EF_UPD:   state_nx = (k_q == LAST_TERM) ? S_EF_END : S_MUL;
			S_EF_END:   state_nx = boot_q ? S_IDLE : S_POW;
			S_POW:      state_nx = (pow_q == 6'd0) ? S_FIN : S_MUL;
			S_FIN: begin
				if (!inv_q || r_q < FLOOR58) begin
					state_nx = S_OUT;
				end else begin
					state_nx = S_RDIV;
				end
			end
			S_RDIV:     state_nx = (cnt_q == 6'd33) ? S_RRND : S_RDIV;
			S_RRND:     state_nx = S_OUT;
			S_OUT:      state_nx = out_free ? S_IDLE : S_OUT;
			default:    state_nx = S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q     <= '0;
			ovalid_q  <= 1'b0;
			cnt_q     <= '0;
			k_q       <= '0;
			pow_q     <= '0;
			i_q       <= '0;
			ph_q      <= 1'b0;
			ctx_pow_q <= 1'b0;
			boot_q    <= 1'b1;
			fnd_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end

			if ((state_q == S_IDLE && in_fire && op_t'(s_tuser) != OP_SURV
				&& op_t'(s_tuser) != OP_RATIO) || (state_q == S_OUT && out_free)) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end

			case (state_q)
				S_INIT, S_EXP: begin
					cnt_q     <= '0;
					k_q       <= 5'd1;
					ctx_pow_q <= 1'b0;
					pow_q     <= x_q[57:52];
				end
				S_IDLE:     ph_q <= 1'b0;
				S_CH_START: begin
					i_q   <= '0;
					fnd_q <= 1'b0;
				end
				S_CH_EVAL:  fnd_q <= seg_hit;
				S_CH_ACC:   i_q <= CW'(i_q + 1'b1);
				S_CH_DONE:  ph_q <= 1'b1;
				S_MUL: begin
					if (cnt_q == 6'd4) begin
						cnt_q <= '0;
						if (ctx_pow_q) begin
							pow_q <= pow_q - 6'd1;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_EF_DIV:   cnt_q <= (cnt_q == 6'd7) ? 6'd0 : cnt_q + 6'd1;
				S_EF_UPD: begin
					k_q   <= k_q + 5'd1;
					cnt_q <= '0;
				end
				S_EF_END:   boot_q <= 1'b0;
				S_POW: begin
					cnt_q     <= '0;
					ctx_pow_q <= 1'b1;
				end
				S_FIN:      cnt_q <= '0;
				S_RDIV:     cnt_q <= cnt_q + 6'd1;
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_INIT: begin
				mul_a_q <= ONE60;
				mul_b_q <= ONE60;
				pos_q   <= ONE60;
				neg_q   <= '0;
			end
			S_IDLE: begin
				op_q <= s_tuser;
				t_q  <= in_query;
				h_q  <= in_horizon;
			end
			S_CH_START: begin
				cum_q   <= '0;
				tprev_q <= '0;
			end
			S_CH_EVAL:  pp_q <= mul_x * mul_y;
			S_CH_ACC: begin
				cum_q   <= cum_sum[64] ? '1 : cum_sum[63:0];
				tprev_q <= pil_end;
			end
			S_CH_DONE: begin
				if (op_t'(op_q) == OP_RATIO && !ph_q) begin
					hs_q <= cum_q;
					t_q  <= h_q;
				end else if (op_t'(op_q) == OP_RATIO && cum_q < hs_q) begin
					x_q   <= hs_q - cum_q;
					inv_q <= 1'b1;
				end else begin
					x_q   <= (op_t'(op_q) == OP_RATIO) ? cum_q - hs_q : cum_q;
					inv_q <= 1'b0;
				end
			end
			S_EXP: begin
				mul_a_q <= ONE60;
				mul_b_q <= {4'd0, x_q[51:0], 8'd0};
				pos_q   <= ONE60;
				neg_q   <= '0;
				r_q     <= '0;
			end
			S_MUL: begin
				if (cnt_q != 6'd4) begin
					pp_q <= mul_x * mul_y;
				end
				acc_q <= acc_nx;
				if (cnt_q == 6'd4) begin
					if (ctx_pow_q) begin
						r_q <= mres;
					end else begin
						dq_q   <= mres;
						drem_q <= '0;
					end
				end
			end
			S_EF_DIV: begin
				dq_q   <= {dq_q[55:0], dv_qb};
				drem_q <= dv_rw[4:0];
			end
			S_EF_UPD: begin
				// Odd terms of the series are subtracted, even terms added.
				if (k_q[0]) begin
					neg_q <= neg_q + dq_q;
				end else begin
					pos_q <= pos_q + dq_q;
				end
				mul_a_q <= dq_q;
			end
			S_EF_END: begin
				if (boot_q) begin
					em1_q <= (pos_q > neg_q) ? pos_q - neg_q : '0;
				end else begin
					r_q <= (pos_q > neg_q) ? pos_q - neg_q : '0;
				end
			end
			S_POW: begin
				mul_a_q <= r_q;
				mul_b_q <= em1_q;
			end
			S_FIN: begin
				if (!inv_q) begin
					fin_q  <= 32'((r_q + HALF_Q230) >> 30);
					fsat_q <= 1'b0;
				end else begin
					// A divisor this small always overflows the Q2.30 range.
					fin_q  <= '1;
					fsat_q <= 1'b1;
				end
				rrem_q <= RDIV_INIT;
				q_q    <= '0;
			end
			S_RDIV: begin
				rrem_q <= rd_ge ? rd_shift - r_q : rd_shift;
				q_q    <= {q_q[32:0], rd_ge};
			end
			S_RRND: begin
				if (q_rnd[33:32] != 2'd0) begin
					fin_q  <= '1;
					fsat_q <= 1'b1;
				end else begin
					fin_q  <= q_rnd[31:0];
					fsat_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase

		if (state_q == S_IDLE && in_fire) begin
			osurv_q <= '0;
			osat_q  <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			osurv_q <= fin_q;
			osat_q  <= fsat_q;
		end
	end

	// The unit only takes a transfer from its idle state.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == S_IDLE)
		else $error("input taken outside idle");

	// A saturated result always carries the clamp value.
	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tdata == '1)
		else $error("saturated result not clamped");

	// The multiply sequence never runs past its last partial product.
	a_mul_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> cnt_q <= 6'd4)
		else $error("multiply step counter out of range");

	// A query starts the hazard walk on the next cycle.
	a_query_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (s_tuser == OP_SURV || s_tuser == OP_RATIO)) |=> state_q == S_CH_START)
		else $error("query did not start the walk");

endmodule

@@ sim/tb_hazard_curve_survival_probability_unit.sv @@
`timescale 1ns / 1ps

module tb_hazard_curve_survival_probability_unit;
	import hcsp_pkg::*;

	localparam int NPIL = MAX_PILLARS_DEF;
	localparam int IDLE_LIMIT = 10000;
	localparam logic [31:0] Q230_ONE = 32'h4000_0000;
	localparam logic [31:0] YEAR = 32'h0100_0000;

	typedef struct {
		logic [1:0]  op;
		logic [3:0]  slot;
		logic [31:0] pend;
		logic [31:0] prate;
		logic [31:0] t_query;
		logic [31:0] t_horizon;
	} curve_item_t;

	typedef struct {
		logic [31:0] surv;
		logic        sat;
	} surv_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [SURV_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// Shadow copy of the curve and the register, advanced as each item is sent.
	logic [31:0] shadow_end [NPIL];
	logic [31:0] shadow_rate [NPIL];
	logic [4:0]  shadow_count = '0;

	curve_item_t  pending_items [$];
	surv_result_t survival_due [$];

	function automatic void append_item(curve_item_t it);
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic void append_due(surv_result_t r);
		survival_due.insert(survival_due.size(), r);
	endfunction

	int errors = 0;
	int n_writes = 0, n_surv = 0, n_ratio = 0, n_sat_seen = 0, n_results = 0;
	int gap_left = 0, burst_left = 4;
	int idle_cycles = 0;
	int cyc = 0;
	int ready_mode = 0;
	logic [31:0] curve_span = YEAR;

	hazard_curve_survival_probability_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// (a * b) >> 60 with the full 128-bit product, truncated to 64 bits.
	function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// exp(-f) in Q.60 by a truncated Taylor series.
	function automatic logic [63:0] exp_series(logic [63:0] f);
		logic [63:0] term, pos, neg;
		term = ONE60;
		pos = ONE60;
		neg = '0;
		for (int k = 1; k <= 24; k++) begin
			term = mul_q60(term, f) / k;
			if (k % 2 == 1) neg += term;
			else pos += term;
		end
		return (pos > neg) ? pos - neg : 64'd0;
	endfunction

	// exp(-x) in Q.60 for a Q12.52 hazard.
	function automatic logic [63:0] decay_q60(logic [63:0] x);
		logic [63:0] r, em1;
		logic [11:0] whole;
		whole = x[63:52];
		if (whole >= 64) return 64'd0;
		r = exp_series({x[51:0], 8'd0} & 64'h0FFF_FFFF_FFFF_FFFF);
		em1 = exp_series(ONE60);
		for (int i = 0; i < whole; i++) r = mul_q60(r, em1);
		return r;
	endfunction

	function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	// Cumulative hazard in Q12.52 up to a signed Q8.24 time.
	function automatic logic [63:0] hazard_to(logic [31:0] t);
		logic [63:0] tprev, acc, e, dt;
		int n;
		tprev = '0;
		acc = '0;
		if (t == 0 || t[31]) return 64'd0;
		n = (shadow_count > NPIL) ? NPIL : shadow_count;
		for (int i = 0; i < n; i++) begin
			e = {32'd0, shadow_end[i]};
			if (e >= {32'd0, t}) begin
				dt = ({32'd0, t} > tprev) ? {32'd0, t} - tprev : 64'd0;
				return add_clamped(acc, {32'd0, shadow_rate[i]} * dt);
			end
			dt = (e > tprev) ? e - tprev : 64'd0;
			acc = add_clamped(acc, {32'd0, shadow_rate[i]} * dt);
			tprev = e;
		end
		return acc;
	endfunction

	function automatic logic [31:0] round_q230(logic [63:0] v);
		logic [64:0] s;
		s = {1'b0, v} + {1'b0, HALF_Q230};
		return s[61:30];
	endfunction

	// Applies one item to the shadow curve and returns the result it must produce.
	function automatic surv_result_t forecast_survival(curve_item_t it);
		surv_result_t res;
		logic [63:0] hs, hh, e, q, r;
		res.surv = '0;
		res.sat = 1'b0;
		case (it.op)
			OP_WRITE: begin
				shadow_end[it.slot] = it.pend;
				shadow_rate[it.slot] = it.prate;
			end
			OP_SURV: res.surv = round_q230(decay_q60(hazard_to(it.t_query)));
			OP_RATIO: begin
				hs = hazard_to(it.t_query);
				hh = hazard_to(it.t_horizon);
				if (hh >= hs) begin
					res.surv = round_q230(decay_q60(hh - hs));
				end else begin
					e = decay_q60(hs - hh);
					if (e < FLOOR58) begin
						res.surv = '1;
						res.sat = 1'b1;
					end else begin
						// Restoring division of 2^91 by e, one extra bit for rounding.
						q = ONE60 / e;
						r = ONE60 % e;
						for (int k = 0; k < 31; k++) begin
							r = r << 1;
							q = q << 1;
							if (r >= e) begin
								r -= e;
								q[0] = 1'b1;
							end
						end
						q = (q + 64'd1) >> 1;
						if (q > 64'hFFFF_FFFF) begin
							res.surv = '1;
							res.sat = 1'b1;
						end else begin
							res.surv = q[31:0];
						end
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Sender: bursts of random length separated by random gaps. The prediction is
	// made when an item is put on the bus; the next one waits for its transfer.
	always @(posedge clk) begin
		curve_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= it.op;
				s_tdata <= {4'd0, it.t_horizon, it.t_query, it.prate, it.pend, it.slot};
				append_due(forecast_survival(it));
				case (it.op)
					OP_WRITE: n_writes++;
					OP_SURV:  n_surv++;
					OP_RATIO: n_ratio++;
					default: ;
				endcase
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: a stall pattern whose character is picked at random from four modes.
	always @(posedge clk) begin
		cyc++;
		if (cyc % 128 == 0) ready_mode = $urandom_range(0, 3);
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				2: m_tready <= (cyc % 4 == 0);
				default: m_tready <= ((cyc / 16) % 2 == 0);
			endcase
		end
	end

	// Checks each result transfer against the oldest prediction.
	always @(posedge clk) begin
		surv_result_t want;
		logic [32:0] diff;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (m_tuser) n_sat_seen++;
			if (survival_due.size() == 0) begin
				$display("%0t: result with nothing outstanding, actual survival %h saturated %b",
					$time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = survival_due.pop_front();
				diff = (m_tdata > want.surv) ? m_tdata - want.surv : want.surv - m_tdata;
				// The datapath is specified to two lsb of Q2.30.
				if (diff > 2) begin
					$display("%0t: survival mismatch, expected %h actual %h",
						$time, want.surv, m_tdata);
					errors++;
				end
				if (m_tuser !== want.sat) begin
					$display("%0t: saturated mismatch, expected %b actual %b",
						$time, want.sat, m_tuser);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("hazard_curve_survival_probability_unit regression: fail");
			$finish;
		end
	end

	function automatic curve_item_t make_item(logic [1:0] op, logic [3:0] slot,
		logic [31:0] pend, logic [31:0] prate, logic [31:0] tq, logic [31:0] th);
		curve_item_t it;
		it.op = op;
		it.slot = slot;
		it.pend = pend;
		it.prate = prate;
		it.t_query = tq;
		it.t_horizon = th;
		return it;
	endfunction

	// Queues sixteen writes that build an ascending curve with random content.
	task automatic queue_sorted_curve();
		logic [31:0] e, rate;
		e = '0;
		for (int i = 0; i < NPIL; i++) begin
			e += $urandom_range(32'h0001_0000, 32'h0300_0000);
			rate = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h1000_0000);
			append_item(make_item(OP_WRITE, 4'(i), e, rate, $urandom, $urandom));
		end
		curve_span = e;
	endtask

	function automatic logic [31:0] pick_time();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6) return $urandom_range(1, curve_span + (curve_span >> 3));
		if (sel == 6) return shadow_end[$urandom_range(0, NPIL - 1)];
		if (sel == 7) return ($urandom_range(0, 1) == 0) ? 32'd0 : 32'h8000_0000 | $urandom;
		return $urandom;
	endfunction

	// Register writes happen only when nothing is in flight.
	task automatic set_pillars(logic [4:0] v);
		while (pending_items.size() > 0 || survival_due.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_count = v;
	endtask

	initial begin
		logic [4:0] phase_counts [5];
		int sel;
		logic [31:0] t1;
		phase_counts = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd9};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Empty curve: every time gives one, and the unused opcode gives zero.
		append_item(make_item(OP_SURV, 0, 0, 0, 32'd0, 32'd0));
		append_item(make_item(OP_SURV, 0, 0, 0, 32'h7FFF_FFFF, 32'd0));
		append_item(make_item(OP_SURV, 0, 0, 0, 32'h8000_0000, 32'd0));
		append_item(make_item(OP_RATIO, 0, 0, 0, 32'h0500_0000, 32'h0100_0000));
		append_item(make_item(2'd3, 4'hF, '1, '1, '1, '1));
		// Ascending curve with extreme rates in the first and last slots.
		for (int i = 0; i < NPIL; i++)
			append_item(make_item(OP_WRITE, 4'(i), YEAR * (i + 1),
				(i == 0) ? 32'd0 : (i == NPIL - 1) ? 32'hFFFF_FFFF : 32'h0200_0000 * i,
				32'd0, 32'd0));
		curve_span = YEAR * NPIL;
		set_pillars(5'd16);
		append_item(make_item(OP_SURV, 0, 0, 0, YEAR >> 1, 0));
		append_item(make_item(OP_SURV, 0, 0, 0, YEAR * 5, 0));
		append_item(make_item(OP_SURV, 0, 0, 0, 32'h0FFF_FFFF, 0));
		append_item(make_item(OP_SURV, 0, 0, 0, 32'h7FFF_FFFF, 0));
		append_item(make_item(OP_RATIO, 0, 0, 0, YEAR * 3, YEAR * 15));
		append_item(make_item(OP_RATIO, 0, 0, 0, YEAR * 15, YEAR * 2));
		append_item(make_item(OP_RATIO, 0, 0, 0, YEAR * 6, YEAR * 5));

		for (int ph = 0; ph < 5; ph++) begin
			set_pillars((ph == 4) ? 5'($urandom_range(2, 15)) : phase_counts[ph]);
			for (int n = 0; n < 170; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 3) begin
					queue_sorted_curve();
				end else if (sel < 8) begin
					// Noise write: any slot, any content, possibly unsorted.
					append_item(make_item(OP_WRITE, 4'($urandom), $urandom, $urandom,
						$urandom, $urandom));
				end else if (sel < 11) begin
					append_item(make_item(2'd3, 4'($urandom), $urandom, $urandom,
						$urandom, $urandom));
				end else if (sel < 55) begin
					append_item(make_item(OP_SURV, 4'($urandom), $urandom, $urandom,
						pick_time(), $urandom));
				end else begin
					t1 = pick_time();
					append_item(make_item(OP_RATIO, 4'($urandom), $urandom, $urandom,
						t1, ($urandom_range(0, 3) == 0) ? t1 + $urandom_range(0, 32'h0100_0000)
						: pick_time()));
				end
			end
		end

		while (pending_items.size() > 0 || survival_due.size() > 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		$display("Covered %0d pillar writes, %0d survival and %0d ratio queries over six settings.",
			n_writes, n_surv, n_ratio);
		$display("Checked %0d results, %0d of them saturated; %0d mismatches.",
			n_results, n_sat_seen, errors);
		if (errors == 0 && survival_due.size() == 0) begin
			$display("hazard_curve_survival_probability_unit regression: pass");
		end else begin
			$display("hazard_curve_survival_probability_unit regression: fail");
		end
		$finish;
	end

endmodule
